// ----- sv/sdr_pkg.sv -----
// Shared types and constants for the bus-mapped signed divider.
// Used by sdr_ctrl, sdr_dp and signed_divider_registers_top; depends on nothing.
package sdr_pkg;

    // Field widths of one bus access and of its read result.
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned OFFSET_W  = 4;
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned DIV_W     = 32;

    // Number of radix-2 steps and the width of their counter.
    localparam int unsigned DIV_STEPS = DIV_W;
    localparam int unsigned STEP_CNT_W = $clog2(DIV_STEPS);

    // Register select code that takes the full 32-bit divisor.
    localparam logic [1:0] SEL_WIDE_DIVISOR = 2'd3;

    // Read offsets of the result registers.
    localparam logic [OFFSET_W-1:0] OFS_RESULT_HI = 4'd4;
    localparam logic [OFFSET_W-1:0] OFS_RESULT_LO = 4'd5;

    // Results forced by a zero divisor.
    localparam logic [DIV_W-1:0]  ZERO_DIV_Q32 = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] ZERO_DIV_Q16 = 16'h7fff;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ITER,
        ST_FIXUP
    } sdr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic setup;
        logic step;
        logic finish;
    } sdr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_req;
        logic div_zero;
    } sdr_sts_t;

endpackage

// ----- sv/sdr_ctrl.sv -----
// Controller of the signed divider: handshakes, divide sequencing and step count.
// Depends on sdr_pkg for the state type and the command and status structs.
module sdr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  sdr_pkg::sdr_sts_t sts,
    output sdr_pkg::sdr_cmd_t cmd
);

    sdr_pkg::sdr_state_t                  state_reg, state_next;
    logic [sdr_pkg::STEP_CNT_W-1:0]       cnt_reg, cnt_next;
    logic                                 m_tvalid_reg, m_tvalid_next;
    logic                                 accept;

    // A new access is taken only between divides and when the output slot frees up.
    assign s_tready = (state_reg == sdr_pkg::ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    // State, step counter and output valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sdr_pkg::ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        cmd.accept    = accept;
        m_tvalid_next = m_tvalid_reg;

        // Every access returns one read word at acceptance.
        if (accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            sdr_pkg::ST_IDLE: begin
                if (accept && sts.div_req) begin
                    state_next = sdr_pkg::ST_SETUP;
                end
            end
            sdr_pkg::ST_SETUP: begin
                cmd.setup = 1'b1;
                cnt_next  = '0;
                state_next = sts.div_zero ? sdr_pkg::ST_IDLE : sdr_pkg::ST_ITER;
            end
            sdr_pkg::ST_ITER: begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == sdr_pkg::STEP_CNT_W'(sdr_pkg::DIV_STEPS - 1)) begin
                    state_next = sdr_pkg::ST_FIXUP;
                end
            end
            sdr_pkg::ST_FIXUP: begin
                cmd.finish = 1'b1;
                state_next = sdr_pkg::ST_IDLE;
            end
            default: begin
                state_next = sdr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/sdr_dp.sv -----
// Datapath of the signed divider: operand and result registers, read mux,
// and a radix-2 restoring divider. Depends on sdr_pkg.
module sdr_dp (
    input  logic                              aclk,
    input  logic                              mode,
    input  logic [sdr_pkg::OFFSET_W-1:0]      offset,
    input  logic [sdr_pkg::WORD_W-1:0]        write_data,
    input  logic [sdr_pkg::WORD_W-1:0]        keep_mask,
    input  logic                              aresetn,
    input  sdr_pkg::sdr_cmd_t                 cmd,
    output sdr_pkg::sdr_sts_t                 sts,
    output logic [sdr_pkg::WORD_W-1:0]        read_data
);

    logic [sdr_pkg::WORD_W-1:0] ops_reg [4];
    logic [sdr_pkg::WORD_W-1:0] res_reg [2];
    logic [sdr_pkg::WORD_W-1:0] rd_reg;
    logic [1:0]                 sel_reg;
    logic                       wide_reg;
    logic                       nd_reg, nv_reg;
    logic [sdr_pkg::DIV_W-1:0]  b_reg;
    logic [sdr_pkg::DIV_W-1:0]  quo_reg;
    logic [sdr_pkg::DIV_W-1:0]  rem_reg;

    logic [sdr_pkg::DIV_W-1:0]  dividend, divisor;
    logic                       nd, nv;
    logic [sdr_pkg::DIV_W:0]    rem_sh, diff;
    logic [sdr_pkg::DIV_W-1:0]  q_signed, r_signed;
    logic [sdr_pkg::WORD_W-1:0] rd_next;
    logic [1:0]                 wsel;

    assign wsel = offset[1:0];

    // Operands as the divide sees them after the triggering write.
    always_comb begin
        dividend = {ops_reg[0], ops_reg[1]};
        if (sel_reg == sdr_pkg::SEL_WIDE_DIVISOR) begin
            divisor = {ops_reg[2], ops_reg[3]};
        end else begin
            divisor = {{sdr_pkg::WORD_W{ops_reg[2][sdr_pkg::WORD_W-1]}}, ops_reg[2]};
        end
        nd = dividend[sdr_pkg::DIV_W-1];
        nv = divisor[sdr_pkg::DIV_W-1];
    end

    assign sts.div_req  = mode && offset[3];
    assign sts.div_zero = (divisor == '0);

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign rem_sh = {rem_reg, quo_reg[sdr_pkg::DIV_W-1]};
    assign diff   = rem_sh - {1'b0, b_reg};

    // Sign fixup of the magnitudes.
    assign q_signed = (nd_reg != nv_reg) ? (sdr_pkg::DIV_W'(0) - quo_reg) : quo_reg;
    assign r_signed = nd_reg ? (sdr_pkg::DIV_W'(0) - rem_reg) : rem_reg;

    // Read word of an access; writes return zero.
    always_comb begin
        rd_next = '0;
        if (!mode) begin
            if (!offset[3] && !offset[2]) begin
                rd_next = ops_reg[offset[1:0]];
            end else if (offset == sdr_pkg::OFS_RESULT_HI) begin
                rd_next = res_reg[0];
            end else if (offset == sdr_pkg::OFS_RESULT_LO) begin
                rd_next = res_reg[1];
            end
        end
    end

    assign read_data = rd_reg;

    // Operand and result registers, cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ops_reg[0] <= '0;
            ops_reg[1] <= '0;
            ops_reg[2] <= '0;
            ops_reg[3] <= '0;
            res_reg[0] <= '0;
            res_reg[1] <= '0;
        end else begin
            if (cmd.accept && mode) begin
                ops_reg[wsel] <= (ops_reg[wsel] & keep_mask) | (write_data & ~keep_mask);
            end
            if (cmd.setup && sts.div_zero) begin
                if (wide_reg) begin
                    res_reg[0] <= sdr_pkg::ZERO_DIV_Q32[sdr_pkg::DIV_W-1:sdr_pkg::WORD_W];
                    res_reg[1] <= sdr_pkg::ZERO_DIV_Q32[sdr_pkg::WORD_W-1:0];
                end else begin
                    res_reg[0] <= sdr_pkg::ZERO_DIV_Q16;
                    res_reg[1] <= sdr_pkg::ZERO_DIV_Q16;
                end
            end else if (cmd.finish) begin
                if (wide_reg) begin
                    res_reg[0] <= q_signed[sdr_pkg::DIV_W-1:sdr_pkg::WORD_W];
                    res_reg[1] <= q_signed[sdr_pkg::WORD_W-1:0];
                end else begin
                    res_reg[0] <= q_signed[sdr_pkg::WORD_W-1:0];
                    res_reg[1] <= r_signed[sdr_pkg::WORD_W-1:0];
                end
            end
        end
    end

    // Read data, divide mode and divider working registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rd_reg   <= rd_next;
            sel_reg  <= wsel;
            wide_reg <= offset[2];
        end
        if (cmd.setup) begin
            nd_reg  <= nd;
            nv_reg  <= nv;
            quo_reg <= nd ? (sdr_pkg::DIV_W'(0) - dividend) : dividend;
            b_reg   <= nv ? (sdr_pkg::DIV_W'(0) - divisor) : divisor;
            rem_reg <= '0;
        end else if (cmd.step) begin
            if (!diff[sdr_pkg::DIV_W]) begin
                rem_reg <= diff[sdr_pkg::DIV_W-1:0];
                quo_reg <= {quo_reg[sdr_pkg::DIV_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[sdr_pkg::DIV_W-1:0];
                quo_reg <= {quo_reg[sdr_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ----- sv/signed_divider_registers_top.sv -----
// Top level of the bus-mapped signed divider.
// Depends on sdr_pkg, sdr_ctrl and sdr_dp.
//
// Each bus access arrives as one transaction on the s_ channel: s_tuser is
// the access kind (0 read, 1 write) and s_tdata carries offset, write data
// and keep mask. Every access returns exactly one transaction on the m_
// channel holding the read word (zero for writes and unmapped offsets).
// The read word appears in the cycle after acceptance, from an output
// register. A write with offset bit 3 set also starts a divide on the
// updated operands: a setup state, 32 restoring steps of the shared
// subtractor and a sign fixup state, or the setup state alone when the
// divisor is zero. No new access is taken until that divide has finished
// writing the result registers.
// When the receiver stalls, the pending read word holds on m_tdata and a
// new access is accepted in the same cycle the old one is taken.
// Synchronous reset clears the operand and result registers and drops
// m_tvalid; the block is ready in the first cycle after reset.
module signed_divider_registers_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [3:0] offset, [19:4] write_data, [35:20] keep_mask, [39:36] zero
    input  logic [sdr_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] mode
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] read_data
    output logic [sdr_pkg::WORD_W-1:0]        m_tdata
);

    sdr_pkg::sdr_cmd_t cmd;
    sdr_pkg::sdr_sts_t sts;

    sdr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sdr_dp u_dp (
        .aclk       (aclk),
        .mode       (s_tuser),
        .offset     (s_tdata[3:0]),
        .write_data (s_tdata[19:4]),
        .keep_mask  (s_tdata[35:20]),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .read_data  (m_tdata)
    );

endmodule

// ----- bench/signed_divider_registers_top_test.sv -----
// Self-checking testbench for signed_divider_registers_top: bus accesses go in on the
// s_ stream, and every read word coming out on the m_ stream is checked against a model.
// Depends on sdr_pkg and on the RTL of the divider.
`timescale 1ns / 1ps

module signed_divider_registers_top_test;

    // Access kinds carried on s_tuser.
    localparam bit ACC_READ  = 1'b0;
    localparam bit ACC_WRITE = 1'b1;

    // Operand register indexes and the control bits of a write offset.
    localparam logic [sdr_pkg::OFFSET_W-1:0] REG_DIVIDEND_HI = 4'd0;
    localparam logic [sdr_pkg::OFFSET_W-1:0] REG_DIVIDEND_LO = 4'd1;
    localparam logic [sdr_pkg::OFFSET_W-1:0] REG_DIVISOR_HI  = 4'd2;
    localparam logic [sdr_pkg::OFFSET_W-1:0] REG_DIVISOR_LO  = 4'd3;
    localparam logic [sdr_pkg::OFFSET_W-1:0] OFS_WIDE        = 4'b0100;
    localparam logic [sdr_pkg::OFFSET_W-1:0] OFS_START       = 4'b1000;
    localparam logic [sdr_pkg::OFFSET_W-1:0] OFS_UNMAPPED_LO = 4'd6;
    localparam logic [sdr_pkg::OFFSET_W-1:0] OFS_UNMAPPED_HI = 4'd15;

    localparam int unsigned ITEMS_PER_PHASE = 250;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned DRAIN_CYCLES    = 80;

    // Model of the register file and divider; holds the read words still to come.
    class read_word_scoreboard;
        logic [sdr_pkg::WORD_W-1:0] operands [4];
        logic [sdr_pkg::WORD_W-1:0] results [2];
        logic [sdr_pkg::WORD_W-1:0] expected_words [$];
        int unsigned                errors;

        function new();
            foreach (operands[i]) operands[i] = '0;
            results[0] = '0;
            results[1] = '0;
            errors     = 0;
        endfunction

        // Signed division of the dividend pair by the selected divisor.
        function void divide_operands(logic [1:0] sel, bit wide);
            logic [sdr_pkg::DIV_W-1:0] num, den, mag_n, mag_d, quo, rem;
            bit                        neg_n, neg_d;
            num = {operands[0], operands[1]};
            if (sel == sdr_pkg::SEL_WIDE_DIVISOR)
                den = {operands[2], operands[3]};
            else
                den = {{sdr_pkg::WORD_W{operands[2][sdr_pkg::WORD_W-1]}}, operands[2]};
            if (den == '0) begin
                if (wide) begin
                    results[0] = sdr_pkg::ZERO_DIV_Q32[sdr_pkg::DIV_W-1:sdr_pkg::WORD_W];
                    results[1] = sdr_pkg::ZERO_DIV_Q32[sdr_pkg::WORD_W-1:0];
                end else begin
                    results[0] = sdr_pkg::ZERO_DIV_Q16;
                    results[1] = sdr_pkg::ZERO_DIV_Q16;
                end
                return;
            end
            neg_n = num[sdr_pkg::DIV_W-1];
            neg_d = den[sdr_pkg::DIV_W-1];
            mag_n = neg_n ? -num : num;
            mag_d = neg_d ? -den : den;
            quo   = mag_n / mag_d;
            rem   = mag_n % mag_d;
            if (neg_n != neg_d) quo = -quo;
            if (neg_n) rem = -rem;
            if (wide) begin
                results[0] = quo[sdr_pkg::DIV_W-1:sdr_pkg::WORD_W];
                results[1] = quo[sdr_pkg::WORD_W-1:0];
            end else begin
                results[0] = quo[sdr_pkg::WORD_W-1:0];
                results[1] = rem[sdr_pkg::WORD_W-1:0];
            end
        endfunction

        // Apply one accepted access to the model and queue its read word.
        function void note_access(bit mode, logic [sdr_pkg::OFFSET_W-1:0] offset,
                                  logic [sdr_pkg::WORD_W-1:0] data,
                                  logic [sdr_pkg::WORD_W-1:0] keep);
            logic [sdr_pkg::WORD_W-1:0] word;
            logic [1:0]                 sel;
            word = '0;
            sel  = offset[1:0];
            if (mode == ACC_WRITE) begin
                operands[sel] = (operands[sel] & keep) | (data & ~keep);
                if (offset[3])
                    divide_operands(sel, offset[2]);
            end else if (offset < sdr_pkg::OFS_RESULT_HI) begin
                word = operands[sel];
            end else if (offset <= sdr_pkg::OFS_RESULT_LO) begin
                word = results[offset[0]];
            end
            expected_words.push_back(word);
        endfunction

        // Compare one read word with the oldest expectation.
        function void check_word(logic [sdr_pkg::WORD_W-1:0] actual);
            logic [sdr_pkg::WORD_W-1:0] want;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected read word %h", $time, actual);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (actual !== want) begin
                $display("%0t: read_data mismatch: expected %h, actual %h",
                         $time, want, actual);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_words.size();
        endfunction
    endclass

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    // [3:0] offset, [19:4] write_data, [35:20] keep_mask, [39:36] zero
    logic [sdr_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    // [0] mode
    logic                          s_tuser  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b1;
    // [15:0] read_data
    logic [sdr_pkg::WORD_W-1:0]    m_tdata;

    read_word_scoreboard sb;
    int unsigned         tx_idle_pct  = 0;
    int unsigned         rx_stall_pct = 0;
    int unsigned         items_sent   = 0;
    int unsigned         cycle_count;

    signed_divider_registers_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    // The receiver stalls at random with the current stall rate.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Results are checked before the input of the same edge is noted, since an
    // access accepted now cannot have its read word out yet.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_access(s_tuser, s_tdata[3:0], s_tdata[19:4], s_tdata[35:20]);
        end
    end

    // Present one access after a random idle gap and hold it until it is taken.
    task automatic send_access(input bit mode, input logic [sdr_pkg::OFFSET_W-1:0] offset,
                               input logic [sdr_pkg::WORD_W-1:0] data,
                               input logic [sdr_pkg::WORD_W-1:0] keep);
        int unsigned gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'd0, keep, data, offset};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Hold off the sender until every read word has come back. The first edge
    // lets the last accepted access reach the scoreboard.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Operand words biased toward the corners of signed arithmetic.
    function automatic logic [sdr_pkg::WORD_W-1:0] pick_word();
        logic [sdr_pkg::WORD_W-1:0] small_val;
        small_val = sdr_pkg::WORD_W'($urandom_range(15));
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'hffff;
            3: return 16'h8000;
            4: return 16'h7fff;
            5: return small_val;
            6: return -small_val;
            default: return sdr_pkg::WORD_W'($urandom);
        endcase
    endfunction

    // Load operands, start a divide in a random mode and read the results back.
    task automatic divide_sequence();
        logic [sdr_pkg::OFFSET_W-1:0] trigger;
        logic [sdr_pkg::WORD_W-1:0]   keep;
        for (int r = 0; r < 4; r++) begin
            keep = ($urandom_range(9) == 0) ? sdr_pkg::WORD_W'($urandom) : '0;
            if (r < 3 || $urandom_range(1))
                send_access(ACC_WRITE, sdr_pkg::OFFSET_W'(r), pick_word(), keep);
        end
        trigger = OFS_START | ($urandom_range(1) ? OFS_WIDE : '0)
                | sdr_pkg::OFFSET_W'($urandom_range(3));
        send_access(ACC_WRITE, trigger, pick_word(), '0);
        send_access(ACC_READ, sdr_pkg::OFS_RESULT_HI, sdr_pkg::WORD_W'($urandom),
                    sdr_pkg::WORD_W'($urandom));
        send_access(ACC_READ, sdr_pkg::OFS_RESULT_LO, sdr_pkg::WORD_W'($urandom),
                    sdr_pkg::WORD_W'($urandom));
        if ($urandom_range(3) == 0)
            send_access(ACC_READ, sdr_pkg::OFFSET_W'($urandom), sdr_pkg::WORD_W'($urandom),
                        sdr_pkg::WORD_W'($urandom));
    endtask

    // Fully random accesses, divides on whatever the registers hold included.
    task automatic random_access();
        send_access(1'($urandom_range(1)), sdr_pkg::OFFSET_W'($urandom),
                    sdr_pkg::WORD_W'($urandom), sdr_pkg::WORD_W'($urandom));
    endtask

    // Watchdog on the whole run.
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge aclk);
        $display("DONE: errors detected");
        $finish;
    end

    // Main sequence: reset, directed corners, then four idling phases.
    initial begin
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers read as zero after reset, and unmapped offsets read as zero.
        send_access(ACC_READ, REG_DIVIDEND_HI, 16'hffff, 16'hffff);
        send_access(ACC_READ, sdr_pkg::OFS_RESULT_LO, 16'h0000, 16'h0000);
        send_access(ACC_READ, OFS_UNMAPPED_HI, 16'h0000, 16'h0000);

        // The most negative dividend over minus one wraps, in both result modes.
        send_access(ACC_WRITE, REG_DIVIDEND_HI, 16'h8000, 16'h0000);
        send_access(ACC_WRITE, REG_DIVIDEND_LO, 16'h0000, 16'h0000);
        send_access(ACC_WRITE, OFS_START | OFS_WIDE | REG_DIVISOR_HI, 16'hffff, 16'h0000);
        send_access(ACC_READ, sdr_pkg::OFS_RESULT_HI, 16'h0000, 16'h0000);
        send_access(ACC_READ, sdr_pkg::OFS_RESULT_LO, 16'h0000, 16'h0000);
        send_access(ACC_WRITE, OFS_START | REG_DIVISOR_HI, 16'hffff, 16'h0000);
        send_access(ACC_READ, sdr_pkg::OFS_RESULT_HI, 16'h0000, 16'h0000);
        send_access(ACC_READ, sdr_pkg::OFS_RESULT_LO, 16'h0000, 16'h0000);

        // A zero divisor saturates, in both result modes.
        send_access(ACC_WRITE, OFS_START | OFS_WIDE | REG_DIVISOR_HI, 16'h0000, 16'h0000);
        send_access(ACC_READ, sdr_pkg::OFS_RESULT_HI, 16'h0000, 16'h0000);
        send_access(ACC_READ, sdr_pkg::OFS_RESULT_LO, 16'h0000, 16'h0000);
        send_access(ACC_WRITE, OFS_START | REG_DIVISOR_HI, 16'h0000, 16'h0000);
        send_access(ACC_READ, sdr_pkg::OFS_RESULT_LO, 16'h0000, 16'h0000);

        // A full 32-bit divisor, and a 16-bit quotient that does not fit.
        send_access(ACC_WRITE, OFS_START | OFS_WIDE | REG_DIVISOR_LO, 16'h0003, 16'h0000);
        send_access(ACC_READ, sdr_pkg::OFS_RESULT_HI, 16'h0000, 16'h0000);
        send_access(ACC_WRITE, OFS_START | REG_DIVISOR_LO, 16'h0003, 16'h0000);
        send_access(ACC_READ, sdr_pkg::OFS_RESULT_LO, 16'h0000, 16'h0000);

        // Keep mask merges old and new bits; a write without the start bit only stores.
        send_access(ACC_WRITE, REG_DIVIDEND_LO, 16'hffff, 16'hff00);
        send_access(ACC_WRITE, OFS_WIDE | REG_DIVISOR_LO, 16'h1234, 16'hffff);
        send_access(ACC_READ, REG_DIVIDEND_LO, 16'h0000, 16'h0000);
        send_access(ACC_READ, REG_DIVISOR_LO, 16'h0000, 16'h0000);
        send_access(ACC_READ, OFS_UNMAPPED_LO, 16'h0000, 16'h0000);
        wait_for_results();

        // Random traffic under each idling pattern, draining between phases.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
                default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
            endcase
            items_sent = 0;
            while (items_sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < 70)
                    divide_sequence();
                else
                    random_access();
            end
            wait_for_results();
        end

        rx_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- signed_divider_registers_top.f -----
sv/sdr_pkg.sv
sv/sdr_ctrl.sv
sv/sdr_dp.sv
sv/signed_divider_registers_top.sv
bench/signed_divider_registers_top_test.sv
